>>> rtl/hba_pkg.sv
`default_nettype none

package hba_pkg;

    // Tree geometry.
    localparam int MAX_LEVELS  = 3;
    localparam int FANOUT_BITS = 5;
    localparam int FANOUT      = 1 << FANOUT_BITS;
    localparam int WORD_W      = FANOUT;

    // Words in the whole tree: 1 + 32 + ... + 32^(MAX_LEVELS-1).
    localparam int TREE_WORDS  = ((1 << (FANOUT_BITS * MAX_LEVELS)) - 1) / (FANOUT - 1);
    localparam int ADDR_W      = $clog2(TREE_WORDS + 1);

    // Path and level counters.
    localparam int PATH_W      = FANOUT_BITS * MAX_LEVELS;
    localparam int LVL_W       = $clog2(MAX_LEVELS + 1);

    // Field widths of the stream and configuration ports.
    localparam int OPCODE_W    = 2;
    localparam int SLOT_W      = 15;
    localparam int COUNT_W     = 16;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd32768;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FIND   = 2'd0,
        OP_MARK   = 2'd1,
        OP_UNMARK = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic eval;
        logic emit;
    } hba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic skip;
        logic walk_done;
        logic out_free;
    } hba_status_t;

endpackage

`default_nettype wire

>>> rtl/hba_ctrl.sv
`default_nettype none

module hba_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire hba_pkg::hba_status_t status,
    output hba_pkg::hba_cmd_t        cmd
);
    import hba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = status.skip ? ST_OUT : ST_EVAL;
            end
            ST_EVAL: begin
                state_next = status.walk_done ? ST_OUT : ST_READ;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ: begin
                cmd = '0;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            ST_OUT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/hba_datapath.sv
`default_nettype none

module hba_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [hba_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [hba_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire hba_pkg::hba_cmd_t             cmd,
    output hba_pkg::hba_status_t               status,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hba_pkg::M_DATA_W-1:0]       m_tdata
);
    import hba_pkg::*;

    localparam int CMP_W = (PATH_W > COUNT_W) ? PATH_W : COUNT_W;

    // Depth of the tree in use for a given slot count.
    function automatic logic [LVL_W-1:0] tree_levels(input logic [COUNT_W-1:0] cnt);
        logic [LVL_W-1:0] lv;
        lv = LVL_W'(1);
        for (int i = 1; i < MAX_LEVELS; i++) begin
            if ((64'd1 << (FANOUT_BITS * i)) < {48'd0, cnt}) begin
                lv = LVL_W'(i + 1);
            end
        end
        return lv;
    endfunction

    // First word of a level.
    function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
        int base;
        base = 0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (i < int'(lvl)) begin
                base = base + (1 << (FANOUT_BITS * i));
            end
        end
        return ADDR_W'(base);
    endfunction

    // Index of the lowest clear bit; 31 when the word is full.
    function automatic logic [FANOUT_BITS-1:0] lowest_clear(input logic [WORD_W-1:0] w);
        logic [FANOUT_BITS-1:0] n;
        n = FANOUT_BITS'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                n = FANOUT_BITS'(i);
            end
        end
        return n;
    endfunction

    logic [WORD_W-1:0]  tree_mem [TREE_WORDS];
    logic [WORD_W-1:0]  rdata_reg;

    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [COUNT_W-1:0] slot_count_reg;
    op_t                op_reg;
    logic               skip_reg;
    logic [PATH_W-1:0]  walk_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [LVL_W-1:0]   levels_reg;
    logic               res_status_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    op_t                in_op;
    logic [SLOT_W-1:0]  in_slot;
    logic [LVL_W-1:0]   in_levels;
    logic               in_skip;

    logic [ADDR_W-1:0]  walk_addr;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;
    logic [WORD_W-1:0]  mem_wdata;

    logic               word_full;
    logic [FANOUT_BITS-1:0] digit;
    logic [PATH_W-1:0]  new_path;
    logic [LVL_W-1:0]   shamt;
    logic [PATH_W-1:0]  partial;
    logic               over_count;
    logic               last_lvl;
    logic [WORD_W-1:0]  bit_mask;
    logic [WORD_W-1:0]  new_word;
    logic               walk_done;

    assign in_op     = op_t'(s_tdata[OPCODE_W-1:0]);
    assign in_slot   = s_tdata[OPCODE_W +: SLOT_W];
    assign in_levels = tree_levels(slot_count_reg);

    // Requests that never touch the tree: the unused opcode, and a mark or
    // unmark aimed past the last slot of the current tree.
    always_comb begin
        unique case (in_op)
            OP_FIND:   in_skip = 1'b0;
            OP_MARK,
            OP_UNMARK: in_skip = (in_slot >> (FANOUT_BITS * int'(in_levels))) != '0;
            default:   in_skip = 1'b1;
        endcase
    end

    // Find indexes a level by the whole path; mark and unmark walk upward
    // and index by the slot with its low digit dropped.
    always_comb begin
        if (op_reg == OP_FIND) begin
            walk_addr = level_base(lvl_reg) + ADDR_W'(walk_reg);
        end else begin
            walk_addr = level_base(lvl_reg) + ADDR_W'(walk_reg >> FANOUT_BITS);
        end
    end

    always_comb begin
        word_full  = &rdata_reg;
        digit      = lowest_clear(rdata_reg);
        new_path   = PATH_W'((walk_reg << FANOUT_BITS) | PATH_W'(digit));
        shamt      = levels_reg - lvl_reg - LVL_W'(1);
        partial    = new_path << (FANOUT_BITS * int'(shamt));
        over_count = CMP_W'(partial) >= CMP_W'(slot_count_reg);
        last_lvl   = lvl_reg == (levels_reg - LVL_W'(1));
        bit_mask   = WORD_W'(1) << walk_reg[FANOUT_BITS-1:0];
        new_word   = (op_reg == OP_MARK) ? (rdata_reg | bit_mask) : (rdata_reg & ~bit_mask);
        unique case (op_reg)
            OP_FIND:   walk_done = word_full || over_count || last_lvl;
            OP_MARK:   walk_done = !(&new_word) || (lvl_reg == '0);
            OP_UNMARK: walk_done = lvl_reg == '0;
            default:   walk_done = 1'b1;
        endcase
    end

    always_comb begin
        if (cmd.clear_wr) begin
            mem_addr  = clr_cnt_reg;
            mem_we    = 1'b1;
            mem_wdata = '0;
        end else begin
            mem_addr  = walk_addr;
            mem_we    = cmd.eval && (op_reg == OP_MARK || op_reg == OP_UNMARK);
            mem_wdata = new_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tree_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= tree_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            slot_count_reg <= COUNT_RESET;
        end else begin
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= in_op;
            skip_reg       <= in_skip;
            levels_reg     <= in_levels;
            res_status_reg <= 1'b0;
            res_slot_reg   <= '0;
            if (in_op == OP_FIND) begin
                walk_reg <= '0;
                lvl_reg  <= '0;
            end else begin
                walk_reg <= PATH_W'(in_slot);
                lvl_reg  <= in_levels - LVL_W'(1);
            end
        end else if (cmd.eval) begin
            if (op_reg == OP_FIND) begin
                if (word_full || over_count) begin
                    res_status_reg <= 1'b1;
                    res_slot_reg   <= '0;
                end else if (last_lvl) begin
                    res_slot_reg <= SLOT_W'(new_path);
                end else begin
                    walk_reg <= new_path;
                    lvl_reg  <= lvl_reg + LVL_W'(1);
                end
            end else if (!walk_done) begin
                walk_reg <= walk_reg >> FANOUT_BITS;
                lvl_reg  <= lvl_reg - LVL_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {res_slot_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.clear_last = clr_cnt_reg == ADDR_W'(TREE_WORDS - 1);
    assign status.skip       = skip_reg;
    assign status.walk_done  = walk_done;
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

>>> rtl/hierarchical_bitmap_allocator.sv
`default_nettype none

// Channel   Direction  Ports                     Contents
// request   in         s_tvalid/s_tready/s_tdata opcode, slot_index
// result    out        m_tvalid/m_tready/m_tdata status, free_slot
// config    in         cfg_wr_en/cfg_wr_data     slot_count
//
// A request is accepted in IDLE; none is taken again until it has left OUT.
// Each level visited has its word read from the single-port tree memory in
// READ, then evaluated and, for mark and unmark, written back in EVAL.
// A request that never touches the tree (the unused opcode, or a mark or
// unmark beyond the tree) goes from READ straight to OUT.
// Mark stops early once a word is not full; find stops at the first failure.
// After reset the tree memory is cleared one word a cycle, all 1057 words,
// and no request is accepted until that pass is done.
// The result is held in an output register, so a stalled result channel only
// blocks the block once it has finished the next request.

module hierarchical_bitmap_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // Request transaction.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] opcode, [16:2] slot_index, [23:17] zero
    input  wire logic [hba_pkg::S_DATA_W-1:0]  s_tdata,

    // Result transaction.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] status, [15:1] free_slot
    output logic [hba_pkg::M_DATA_W-1:0]       m_tdata,

    // Configuration: slot_count, taken whenever the write enable is high.
    input  wire logic                          cfg_wr_en,
    input  wire logic [hba_pkg::COUNT_W-1:0]   cfg_wr_data
);
    import hba_pkg::*;

    hba_cmd_t    cmd;
    hba_status_t status;

    // The controller sequences the clearing pass and the level-by-level walk.
    hba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the tree memory, the walk registers and the
    // output register.
    hba_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

>>> verif/hierarchical_bitmap_allocator_tb.sv
`timescale 1ns / 100ps

module hierarchical_bitmap_allocator_tb;
    import hba_pkg::*;

    // Opcode 3 is not a real operation; the block must answer it with a clean result.
    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

    // This drain outlasts a request that walks all three levels, so it covers a request still in work.
    localparam int DRAIN_CYCLES = 16;
    // The receiver holds off this long so that the output register and the request
    // path both fill up and s_tready has to drop.
    localparam int LONG_HOLD    = 300;
    // The clearing pass after reset and about 1100 requests, each slowed at worst by
    // the block, a sender gap and a receiver stall, stay far below this limit.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 130;
    localparam int PRINT_LIMIT  = 40;

    // What one request is expected to return, with the request kept for messages.
    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [SLOT_W-1:0]   slot_index;
        logic                status;
        logic [SLOT_W-1:0]   free_slot;
    } slot_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]    cfg_wr_data = '0;

    // The testbench's own copy of the tree and of the slot count.
    logic [WORD_W-1:0]     used_map [TREE_WORDS];
    int unsigned           count_setting = 32768;

    logic [S_DATA_W-1:0]   queued_requests [$];
    slot_result_t          pending_results [$];

    int unsigned           requests_accepted = 0;
    int unsigned           error_count       = 0;
    int unsigned           cycle_count       = 0;
    int unsigned           send_gap          = 0;
    int unsigned           recv_stall        = 0;
    logic                  idle_enable       = 1'b1;
    logic                  hold_off          = 1'b0;

    hierarchical_bitmap_allocator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Number of tree levels in use: the smallest depth whose span covers the slot count.
    function automatic int unsigned tree_depth();
        int unsigned levels;
        levels = 1;
        while (levels < MAX_LEVELS && (32'd1 << (FANOUT_BITS * levels)) < count_setting)
            levels++;
        return levels;
    endfunction

    // Index of the first word of a level: 0, 1, 33, ...
    function automatic int unsigned level_base(int unsigned level);
        return ((1 << (FANOUT_BITS * level)) - 1) / (FANOUT - 1);
    endfunction

    // Sets or clears one leaf bit. A set carries upward only while words become
    // full; a clear walks every level and clears the ancestor bits on the way.
    function automatic void update_leaf(int unsigned pos, logic set_bit);
        int unsigned       depth;
        int unsigned       level;
        int unsigned       word_idx;
        logic [WORD_W-1:0] word;
        depth = tree_depth();
        if (pos >= (32'd1 << (FANOUT_BITS * depth)))
            return;
        for (level = depth; level > 0; level--) begin
            word_idx = pos >> FANOUT_BITS;
            word = used_map[level_base(level - 1) + word_idx];
            word[pos % FANOUT] = set_bit;
            used_map[level_base(level - 1) + word_idx] = word;
            pos = word_idx;
            if (set_bit && word != '1)
                break;
            if (!set_bit && word == '1)
                break;
        end
    endfunction

    // Applies one request to the local tree and returns the result it should give.
    function automatic slot_result_t apply_request(logic [S_DATA_W-1:0] req);
        slot_result_t      res;
        int unsigned       depth;
        int unsigned       level;
        int unsigned       bit_pos;
        logic [31:0]       path;
        logic [WORD_W-1:0] word;
        res.opcode     = req[OPCODE_W-1:0];
        res.slot_index = req[OPCODE_W +: SLOT_W];
        res.status     = 1'b0;
        res.free_slot  = '0;
        case (res.opcode)
            OP_FIND: begin
                // Walk from the root along the lowest clear bits. A full word on the
                // way, or a partial slot at or past the count, means no free slot.
                depth = tree_depth();
                path  = '0;
                for (level = 0; level < depth && !res.status; level++) begin
                    word = used_map[level_base(level) + path];
                    if (word == '1) begin
                        res.status = 1'b1;
                    end else begin
                        bit_pos = 0;
                        while (bit_pos < WORD_W - 1 && word[bit_pos])
                            bit_pos++;
                        path = (path << FANOUT_BITS) | bit_pos;
                        if ((path << (FANOUT_BITS * (depth - level - 1))) >= count_setting)
                            res.status = 1'b1;
                    end
                end
                if (!res.status)
                    res.free_slot = path[SLOT_W-1:0];
            end
            OP_MARK:   update_leaf(res.slot_index, 1'b1);
            OP_UNMARK: update_leaf(res.slot_index, 1'b0);
            default: ;
        endcase
        return res;
    endfunction

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_enable || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic queue_request(input logic [OPCODE_W-1:0] opcode,
                                 input int unsigned slot);
        queued_requests.push_back({{(S_DATA_W - OPCODE_W - SLOT_W){1'b0}},
                                   slot[SLOT_W-1:0], opcode});
    endtask

    // The configuration may only change while nothing is in flight. Polling at the
    // falling edge sees the state left by the last rising edge without a race.
    task automatic wait_until_idle();
        do
            @(negedge aclk);
        while (queued_requests.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slot_count(input int unsigned value);
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value[COUNT_W-1:0];
        count_setting  = value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
    endtask

    // Builds one phase of random requests. Most of it is an allocator-like fill: a
    // cursor marks consecutive slots so that leaf words, then inner words, go full,
    // with finds in between and unmarks that reopen holes behind the cursor. The
    // rest is noise: stray marks, the unused opcode and slots anywhere in 15 bits.
    task automatic queue_phase(input int unsigned items);
        int unsigned       span;
        int unsigned       base;
        int unsigned       cursor;
        int unsigned       kind;
        int unsigned       slot;
        int unsigned       n;
        logic [OPCODE_W-1:0] opcode;
        span   = 32'd1 << (FANOUT_BITS * tree_depth());
        base   = (count_setting > 64) ? ($urandom_range(0, (count_setting - 1) >> 5) << 5) : 0;
        cursor = base;
        for (n = 0; n < items; n++) begin
            kind = $urandom_range(0, 99);
            slot = $urandom_range(0, 32767);
            if (kind < 45) begin
                opcode = OP_MARK;
                slot   = cursor & (span - 1);
                cursor++;
            end else if (kind < 70) begin
                opcode = OP_FIND;
            end else if (kind < 82) begin
                opcode = OP_UNMARK;
                if (cursor > base)
                    slot = (base + $urandom_range(0, cursor - base - 1)) & (span - 1);
                else
                    slot = base & (span - 1);
            end else if (kind < 90) begin
                opcode = OP_MARK;
                slot   = (base + $urandom_range(0, 63)) & (span - 1);
            end else if (kind < 95) begin
                opcode = OP_NOP;
            end else begin
                opcode = ($urandom_range(0, 1) == 0) ? OP_MARK : OP_UNMARK;
            end
            queue_request(opcode, slot);
        end
    endtask

    // Request driver. A new request is put on the bus once the previous one has been
    // taken and the chosen gap has run out; the predictor runs at the accepting edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(apply_request(s_tdata));
                requests_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    s_tdata  <= queued_requests.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result transaction is checked against the oldest
    // expectation; m_tready drops for random stalls and for the long hold-off.
    always @(posedge aclk) begin : result_monitor
        slot_result_t oldest;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result 0x%h arrived with no request outstanding",
                                              m_tdata));
                end else begin
                    oldest = pending_results.pop_front();
                    if (m_tdata[0] !== oldest.status)
                        report_mismatch($sformatf("op %0d slot %0d: status %b, expected %b",
                                                  oldest.opcode, oldest.slot_index,
                                                  m_tdata[0], oldest.status));
                    if (m_tdata[M_DATA_W-1:1] !== oldest.free_slot)
                        report_mismatch($sformatf("op %0d slot %0d: free_slot %0d, expected %0d",
                                                  oldest.opcode, oldest.slot_index,
                                                  m_tdata[M_DATA_W-1:1], oldest.free_slot));
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end else if (hold_off) begin
                m_tready   <= 1'b0;
            end else if ($urandom_range(0, 99) < 20) begin
                recv_stall <= pick_gap();
                m_tready   <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
            end
        end
    end

    // Two long hold-offs on the result side while the sender keeps offering requests.
    initial begin : receiver_hold_off
        wait (requests_accepted >= 120);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_off <= 1'b0;
        wait (requests_accepted >= 650);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned setting;
        foreach (used_map[i])
            used_map[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset count of 32768 slots (three levels): a find
        // on the empty tree, marks and unmarks at both ends of the slot range, and the
        // unused opcode carrying an all-ones slot field.
        queue_request(OP_FIND,   0);
        queue_request(OP_MARK,   0);
        queue_request(OP_FIND,   32767);
        queue_request(OP_MARK,   32767);
        queue_request(OP_UNMARK, 32767);
        queue_request(OP_UNMARK, 0);
        queue_request(OP_NOP,    32767);
        queue_request(OP_FIND,   0);
        queue_request(OP_MARK,   1);
        wait_until_idle();

        // A single slot gives a one-level tree: a find that succeeds, then one that
        // runs into the bound, a mark on a slot outside the tree, and an unmark of a
        // slot inside the tree but beyond the count.
        write_slot_count(1);
        queue_request(OP_FIND,   0);
        queue_request(OP_MARK,   0);
        queue_request(OP_FIND,   0);
        queue_request(OP_MARK,   32);
        queue_request(OP_UNMARK, 5);
        queue_request(OP_MARK,   5);
        queue_request(OP_FIND,   0);
        queue_request(OP_UNMARK, 0);
        queue_request(OP_FIND,   0);
        wait_until_idle();

        // Random phases over a range of slot counts. The tree is never cleared in
        // between, so shrinking and growing the count leaves full inner words and
        // marks beyond the count for later walks to run into. Phase 3 has no idle gaps
        // on either side, though the receiver still drops m_tready at random.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       setting = 32;
                1:       setting = 1;
                2:       setting = 33;
                3:       setting = 1024;
                4:       setting = 1025;
                5:       setting = $urandom_range(2, 31);
                6:       setting = $urandom_range(1026, 32767);
                default: setting = 32768;
            endcase
            idle_enable = (phase != 3);
            write_slot_count(setting);
            queue_phase(PHASE_ITEMS);
            wait_until_idle();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> hierarchical_bitmap_allocator.f
rtl/hba_pkg.sv
rtl/hba_ctrl.sv
rtl/hba_datapath.sv
rtl/hierarchical_bitmap_allocator.sv
verif/hierarchical_bitmap_allocator_tb.sv
